// ===== hw/rtl/sse_pkg.sv =====
// sse_pkg: shared types and constants for the shell sort engine
// holds the datapath operation codes and the controller/datapath status struct
// no dependencies
package sse_pkg;

  typedef logic [3:0] op_t;

  localparam op_t OP_IDLE      = 4'd0;
  localparam op_t OP_LOAD      = 4'd1;
  localparam op_t OP_SORT_INIT = 4'd2;
  localparam op_t OP_RD_I      = 4'd3;
  localparam op_t OP_GAP_HALF  = 4'd4;
  localparam op_t OP_CAP_HELD  = 4'd5;
  localparam op_t OP_SHIFT     = 4'd6;
  localparam op_t OP_PUT_HELD  = 4'd7;
  localparam op_t OP_RD_K      = 4'd8;
  localparam op_t OP_OUT_LOAD  = 4'd9;
  localparam op_t OP_OUT_DONE  = 4'd10;

  typedef struct packed {
    logic gap_zero;
    logic i_lt_n;
    logic held_less;
    logic j_ge_2gap;
    logic last_k;
  } sse_stat_t;

endpackage

// ===== hw/rtl/sse_datapath.sv =====
// sse_datapath: key store memory, counters, held key and output register
// executes one op_t per cycle from sse_ctrl, uses sse_pkg
module sse_datapath
  import sse_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  op_t                 op,
  input  logic signed [31:0]  in_key_value,
  output sse_stat_t           stat,
  output logic signed [31:0]  out_sorted_key,
  output logic                out_final_key
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  logic [KEY_BITS-1:0] mem [MAX_ITEMS];
  logic [KEY_BITS-1:0] rdata_r;
  logic [KEY_BITS-1:0] held_r, held_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic                out_final_r, out_final_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       gap_r, gap_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;
  logic                we;
  logic [CW-1:0]       j_m_gap;
  logic [CW-1:0]       j_m_2gap;

  assign j_m_gap  = j_r - gap_r;
  assign j_m_2gap = j_m_gap - gap_r;

  always_comb begin
    count_nxt     = count_r;
    gap_nxt       = gap_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    held_nxt      = held_r;
    out_key_nxt   = out_key_r;
    out_final_nxt = out_final_r;
    raddr         = j_m_gap[AW-1:0];
    waddr         = j_r[AW-1:0];
    wdata         = held_r;
    we            = 1'b0;
    unique case (op)
      OP_LOAD: begin
        if (count_r < FULL) begin
          we        = 1'b1;
          waddr     = count_r[AW-1:0];
          wdata     = KEY_BITS'($unsigned(in_key_value));
          count_nxt = count_r + ONE;
        end
      end
      OP_SORT_INIT: begin
        gap_nxt = count_r >> 1;
        i_nxt   = count_r >> 1;
        k_nxt   = '0;
      end
      OP_RD_I: begin
        raddr = i_r[AW-1:0];
        j_nxt = i_r;
      end
      OP_GAP_HALF: begin
        gap_nxt = gap_r >> 1;
        i_nxt   = gap_r >> 1;
      end
      OP_CAP_HELD: begin
        held_nxt = rdata_r;
        raddr    = j_m_gap[AW-1:0];
      end
      OP_SHIFT: begin
        // move the larger key up one gap and look one gap further down
        we    = 1'b1;
        wdata = rdata_r;
        j_nxt = j_m_gap;
        raddr = j_m_2gap[AW-1:0];
      end
      OP_PUT_HELD: begin
        we    = 1'b1;
        i_nxt = i_r + ONE;
      end
      OP_RD_K: begin
        raddr = k_r[AW-1:0];
      end
      OP_OUT_LOAD: begin
        out_key_nxt   = rdata_r;
        out_final_nxt = (k_r + ONE) == count_r;
      end
      OP_OUT_DONE: begin
        k_nxt = k_r + ONE;
        if (out_final_r) begin
          count_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r       <= gap_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    held_r      <= held_nxt;
    out_key_r   <= out_key_nxt;
    out_final_r <= out_final_nxt;
  end

  assign stat.gap_zero  = (gap_r == '0);
  assign stat.i_lt_n    = (i_r < count_r);
  assign stat.held_less = ($signed(held_r) < $signed(rdata_r));
  assign stat.j_ge_2gap = ({1'b0, j_r} >= {gap_r, 1'b0});
  assign stat.last_k    = out_final_r;

  assign out_sorted_key = 32'($unsigned(out_key_r));
  assign out_final_key  = out_final_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("key count beyond store depth");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_SHIFT |-> (j_r >= gap_r && gap_r != '0))
    else $error("shift below the bottom of the gapped run");

endmodule

// ===== hw/rtl/sse_ctrl.sv =====
// sse_ctrl: sequencer for load, gapped insertion passes and emission
// drives op_t commands into sse_datapath from its status, uses sse_pkg
module sse_ctrl
  import sse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_end_of_set,
  output logic      out_valid,
  input  logic      out_ready,
  input  sse_stat_t stat,
  output op_t       op
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_PASS  = 3'd2;
  localparam logic [2:0] ST_GETH  = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_PUT   = 3'd5;
  localparam logic [2:0] ST_ERD   = 3'd6;
  localparam logic [2:0] ST_EOUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       ewait_r, ewait_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    ewait_nxt     = 1'b0;
    op            = OP_IDLE;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (in_end_of_set) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        op        = OP_SORT_INIT;
        state_nxt = ST_PASS;
      end
      ST_PASS: begin
        priority if (stat.gap_zero) begin
          state_nxt = ST_ERD;
        end else if (stat.i_lt_n) begin
          op        = OP_RD_I;
          state_nxt = ST_GETH;
        end else begin
          op = OP_GAP_HALF;
        end
      end
      ST_GETH: begin
        op        = OP_CAP_HELD;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.held_less) begin
          op = OP_SHIFT;
          if (!stat.j_ge_2gap) begin
            state_nxt = ST_PUT;
          end
        end else begin
          op        = OP_PUT_HELD;
          state_nxt = ST_PASS;
        end
      end
      ST_PUT: begin
        op        = OP_PUT_HELD;
        state_nxt = ST_PASS;
      end
      ST_ERD: begin
        // read address this cycle; the data passes through the read register into the output register
        op        = OP_RD_K;
        ewait_nxt = 1'b1;
        state_nxt = ST_EOUT;
      end
      ST_EOUT: begin
        priority if (ewait_r) begin
          op            = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
        end else if (out_ready) begin
          op            = OP_OUT_DONE;
          out_valid_nxt = 1'b0;
          state_nxt     = stat.last_k ? ST_LOAD : ST_ERD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
      ewait_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ewait_r     <= ewait_nxt;
    end
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;

  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_EOUT && !ewait_r))
    else $error("result valid outside the emit state");

  a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && stat.last_k) |=> state_r == ST_LOAD)
    else $error("no return to loading after the final key");

  a_cmp_gap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> !stat.gap_zero)
    else $error("compare step with zero gap");

endmodule

// ===== hw/rtl/shell_sort_engine.sv =====
// shell_sort_engine: top level, loads keys, shell sorts them, streams them out
// instantiates sse_ctrl and sse_datapath, uses sse_pkg
//
//   channel  ports                                  direction
//   in       in_valid in_ready in_key_value in_end_of_set   into block
//   out      out_valid out_ready out_sorted_key out_final_key  out of block
//
// loading accepts one key per cycle; keys beyond MAX_ITEMS are dropped
// each insertion step reads and captures the key, compare-moves it one gap per shift
// and places it; each gap change is its own step; the key store has one read port
// emission reads each key, loads it into the output register, holds it until out_ready
// reset is synchronous active low; it clears the key count and returns to loading
// no input is taken from the end of set until the final key has been delivered
module shell_sort_engine
  import sse_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_key_value,
  input  logic               in_end_of_set,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sorted_key,
  output logic               out_final_key
);

  op_t       op;
  sse_stat_t stat;

  sse_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_end_of_set (in_end_of_set),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .stat          (stat),
    .op            (op)
  );

  sse_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_BITS  (KEY_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .in_key_value   (in_key_value),
    .stat           (stat),
    .out_sorted_key (out_sorted_key),
    .out_final_key  (out_final_key)
  );

endmodule

// ===== verif/tb_shell_sort_engine.sv =====
// tb_shell_sort_engine: self-checking testbench for the shell sort engine
// predicts each sorted set from the accepted keys and checks every output transaction
// depends only on shell_sort_engine and the files it instantiates
module tb_shell_sort_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 64;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] key;
    logic               is_final;
  } sorted_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_key_value = '0;
  logic               in_end_of_set = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_sorted_key;
  logic               out_final_key;

  // keys of the set being loaded, and sorted keys still owed by the block
  logic signed [31:0] loaded_keys[$];
  sorted_entry_t      sorted_expect[$];

  int  errors = 0;
  int  hold_off = 0;
  bit  idle_on = 1'b1;

  shell_sort_engine #(
    .MAX_ITEMS(STORE_DEPTH),
    .KEY_BITS (32)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_value  (in_key_value),
    .in_end_of_set (in_end_of_set),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sorted_key(out_sorted_key),
    .out_final_key (out_final_key)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [31:0] rand_key();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return $signed($urandom_range(0, 6)) - 3;  // narrow range gives equal keys
      default: return $signed($urandom());
    endcase
  endfunction

  // shell sort with halving gaps over the loaded keys, queued as expected output
  function automatic void sort_loaded_set();
    logic signed [31:0] keys[];
    logic signed [31:0] held;
    int                 n, gap, i, j;
    sorted_entry_t      ent;
    n = loaded_keys.size();
    keys = new[n];
    foreach (loaded_keys[k]) keys[k] = loaded_keys[k];
    for (gap = n / 2; gap > 0; gap = gap / 2) begin
      for (i = gap; i < n; i++) begin
        held = keys[i];
        j = i;
        while (j >= gap && held < keys[j - gap]) begin
          keys[j] = keys[j - gap];
          j -= gap;
        end
        keys[j] = held;
      end
    end
    for (i = 0; i < n; i++) begin
      ent.key = keys[i];
      ent.is_final = (i == n - 1);
      sorted_expect.push_back(ent);
    end
    loaded_keys.delete();
  endfunction

  function automatic void load_key(logic signed [31:0] key, logic eos);
    if (loaded_keys.size() < STORE_DEPTH) loaded_keys.push_back(key);
    if (eos) sort_loaded_set();
  endfunction

  // called and returns on a falling edge; valid stays high into the next item when
  // there is no gap
  task automatic send_key(input logic signed [31:0] key, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_key_value  <= key;
    in_end_of_set <= eos;
    do @(posedge clk); while (!in_ready);
    load_key(key, eos);
    @(negedge clk);
  endtask

  task automatic send_set(input int count);
    for (int i = 0; i < count; i++) send_key(rand_key(), i == count - 1);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sorted_expect.size() != 0) @(negedge clk);
  endtask

  task automatic test_single_key();
    send_key(KEY_MAX, 1'b1);
  endtask

  task automatic test_extreme_keys();
    send_key(0, 1'b0);
    send_key(-1, 1'b0);
    send_key(KEY_MAX, 1'b0);
    send_key(KEY_MIN, 1'b0);
    send_key(1, 1'b0);
    send_key(KEY_MAX, 1'b0);
    send_key(KEY_MIN, 1'b1);
  endtask

  task automatic test_equal_and_reversed();
    for (int i = 0; i < 4; i++) send_key(32'sd77, i == 3);
    for (int i = 0; i < 6; i++) send_key(32'sd500 - 100 * i, i == 5);
  endtask

  // exactly full, then overflow where the closing item itself is dropped
  task automatic test_full_store();
    send_set(STORE_DEPTH);
    send_set(STORE_DEPTH + 2);
  endtask

  // receiver stops for a long stretch while the sender keeps offering a new set
  task automatic test_backpressure();
    release_input();
    wait_drained();
    hold_off = 300;
    send_set(8);
    send_set(5);
  endtask

  task automatic test_random_sets();
    int sent, size, r;
    sent = 0;
    while (sent < 200) begin
      r = $urandom_range(0, 99);
      if (r < 70) size = $urandom_range(1, 8);
      else if (r < 92) size = $urandom_range(9, 24);
      else size = $urandom_range(25, STORE_DEPTH);
      idle_on = ($urandom_range(0, 3) != 0);
      send_set(size);
      sent += size;
    end
    idle_on = 1'b1;
  endtask

  // receiver
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // result check
  always @(posedge clk) begin
    sorted_entry_t exp_ent;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected transaction: sorted_key %0d final_key %0b",
               out_sorted_key, out_final_key);
        errors++;
      end else begin
        exp_ent = sorted_expect.pop_front();
        if (out_sorted_key !== exp_ent.key) begin
          $error("sorted_key mismatch: expected %0d actual %0d", exp_ent.key, out_sorted_key);
          errors++;
        end
        if (out_final_key !== exp_ent.is_final) begin
          $error("final_key mismatch: expected %0b actual %0b",
                 exp_ent.is_final, out_final_key);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_shell_sort_engine failed");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_single_key();
    test_extreme_keys();
    test_equal_and_reversed();
    test_full_store();
    test_backpressure();
    test_random_sets();
    release_input();
    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("tb_shell_sort_engine passed");
    end else begin
      $display("tb_shell_sort_engine failed");
    end
    $finish;
  end

endmodule
